FILE: src/slr_pkg.sv
// shared types, constants and palette for the segment label recolor block
package slr_pkg;

	localparam int MAX_LABELS = 256;
	localparam int NUM_COLORS = 13;
	localparam int LABEL_W    = 24;
	localparam int COLOR_W    = 24;
	localparam int PHASE_W    = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;

	localparam logic [COLOR_W-1:0] WHITE = 24'hffffff;

	localparam logic [PHASE_W-1:0] FIRST_PHASE = PHASE_W'(1 % NUM_COLORS);
	localparam logic [PHASE_W-1:0] FULL_PHASE  = PHASE_W'((MAX_LABELS + 1) % NUM_COLORS);

	// token that walks down the cell chain, one cell per cycle while the chain advances
	typedef struct packed {
		logic               valid;
		logic [LABEL_W-1:0] label;
		logic               last;
		logic               bg;
		logic               hit;
		logic [PHASE_W-1:0] res_phase;
		logic [PHASE_W-1:0] walk_phase;
	} token_t;

	function automatic logic [PHASE_W-1:0] phase_inc(input logic [PHASE_W-1:0] p);
		logic [PHASE_W-1:0] r;
		if (p == PHASE_W'(NUM_COLORS - 1)) begin
			r = '0;
		end else begin
			r = p + PHASE_W'(1);
		end
		return r;
	endfunction

	function automatic logic [COLOR_W-1:0] palette(input logic [PHASE_W-1:0] p);
		logic [COLOR_W-1:0] c;
		case (p)
			4'd0:    c = 24'hff00ff;
			4'd1:    c = 24'h009f4f;
			4'd2:    c = 24'hff0000;
			4'd3:    c = 24'h0000ff;
			4'd4:    c = 24'hff0000;
			4'd5:    c = 24'hffff00;
			4'd6:    c = 24'h6f007f;
			4'd7:    c = 24'h00ff00;
			4'd8:    c = 24'h004f9f;
			4'd9:    c = 24'h7f9f00;
			4'd10:   c = 24'haf006f;
			4'd11:   c = 24'h00ffff;
			4'd12:   c = 24'hff5f00;
			default: c = WHITE;
		endcase
		return c;
	endfunction

endpackage

FILE: src/slr_pix_if.sv
// pixel label channel
interface slr_pix_if;
	logic        valid;
	logic        ready;
	logic [23:0] label;
	logic        last_pixel;

	modport source (output valid, output label, output last_pixel, input ready);
	modport sink   (input valid, input label, input last_pixel, output ready);
endinterface

FILE: src/slr_rgb_if.sv
// pixel color channel
interface slr_rgb_if;
	logic        valid;
	logic        ready;
	logic [23:0] color;
	logic        table_overflow;

	modport source (output valid, output color, output table_overflow, input ready);
	modport sink   (input valid, input color, input table_overflow, output ready);
endinterface

FILE: src/slr_cell.sv
// one table entry of the label chain, compares or captures the passing token
module slr_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  slr_pkg::token_t tok_in,
	output slr_pkg::token_t tok_out
);
	import slr_pkg::*;

	logic               valid_q;
	logic [LABEL_W-1:0] label_q;
	token_t             tok_q;
	token_t             tok_nx;
	logic               live;
	logic               capture;

	always_comb begin
		tok_nx            = tok_in;
		tok_nx.walk_phase = phase_inc(tok_in.walk_phase);
		live              = tok_in.valid && !tok_in.bg && !tok_in.hit;
		capture           = live && !valid_q;
		if (live && (!valid_q || label_q == tok_in.label)) begin
			tok_nx.hit       = 1'b1;
			tok_nx.res_phase = tok_in.walk_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			valid_q <= 1'b0;
		end else if (adv) begin
			tok_q <= tok_nx;
			if (tok_in.valid && tok_in.last) begin
				valid_q <= 1'b0;
			end else if (capture) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && capture) begin
			label_q <= tok_in.label;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: src/slr_tail.sv
// end of chain: color lookup, overflow numbering and result register
module slr_tail (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  slr_pkg::token_t             tok_in,
	output logic                        res_valid,
	output logic [slr_pkg::COLOR_W-1:0] res_color,
	output logic                        res_ovf
);
	import slr_pkg::*;

	logic               valid_q;
	logic [COLOR_W-1:0] color_q;
	logic               ovf_q;
	logic [PHASE_W-1:0] ovf_phase_q;
	logic [COLOR_W-1:0] color_nx;
	logic               ovf_nx;

	always_comb begin
		ovf_nx = 1'b0;
		if (tok_in.bg) begin
			color_nx = WHITE;
		end else if (tok_in.hit) begin
			color_nx = palette(tok_in.res_phase);
		end else begin
			// table full: numbering goes on past the last entry
			color_nx = palette(ovf_phase_q);
			ovf_nx   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			ovf_phase_q <= FULL_PHASE;
		end else if (adv) begin
			valid_q <= tok_in.valid;
			if (tok_in.valid) begin
				if (tok_in.last) begin
					ovf_phase_q <= FULL_PHASE;
				end else if (ovf_nx) begin
					ovf_phase_q <= phase_inc(ovf_phase_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			color_q <= color_nx;
			ovf_q   <= ovf_nx;
		end
	end

	assign res_valid = valid_q;
	assign res_color = color_q;
	assign res_ovf   = ovf_q;

endmodule

FILE: src/segment_label_recolor_core.sv
// top level of the segment label recolor block
//
//  channel | dir | payload                   | transaction
//  pix     | in  | label[23:0], last_pixel   | pix.valid && pix.ready
//  rgb     | out | color[23:0], table_overflow| rgb.valid && rgb.ready
//
// one pixel per cycle while the chain advances; each pixel walks the chain of MAX_LABELS
// cells, one cell per cycle, and its color is then registered in the result register
// of the tail, behind the last cell
// the whole chain advances together; it halts only while the result
// register holds a color that the sink does not take
// reset clears the valid bit in every cell at once, no clearing pass
// a last pixel clears each cell as it passes, so the next image starts empty
module segment_label_recolor_core (
	input  logic      clk,
	input  logic      arst_n,
	slr_pix_if.sink   pix,
	slr_rgb_if.source rgb
);
	import slr_pkg::*;

	// tok[k] enters cell k; tok[MAX_LABELS] leaves the last cell
	token_t tok [MAX_LABELS+1];
	logic   adv;
	logic   res_valid;

	// chain moves when the result register is free or being drained
	assign adv       = !res_valid || rgb.ready;
	assign pix.ready = adv;

	// new token: background is resolved here, numbering starts at one
	always_comb begin
		tok[0].valid      = pix.valid;
		tok[0].label      = pix.label;
		tok[0].last       = pix.last_pixel;
		tok[0].bg         = (pix.label == '0);
		tok[0].hit        = 1'b0;
		tok[0].res_phase  = '0;
		tok[0].walk_phase = FIRST_PHASE;
	end

	// entry k holds number k+1; labels fill from the front in arrival order
	for (genvar k = 0; k < MAX_LABELS; k++) begin : g_cell
		slr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

	slr_tail u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.tok_in    (tok[MAX_LABELS]),
		.res_valid (res_valid),
		.res_color (rgb.color),
		.res_ovf   (rgb.table_overflow)
	);

	assign rgb.valid = res_valid;

endmodule

FILE: tb/segment_label_recolor_core_test.sv
// self-checking testbench for segment_label_recolor_core: random pixel streams, scoreboard
module segment_label_recolor_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import slr_pkg::*;

	// generous cycle budget for the watchdog
	localparam int CYCLE_LIMIT = 300000;
	// length of the final quiet drain after all colors are back
	localparam int DRAIN_CYCLES = MAX_LABELS + 64;
	localparam int ITEM_TARGET = 1100;
	// number of trailing pixels sent with no idling on either side
	localparam int CALM_TAIL = 120;
	localparam int MAX_SHOWN = 10;

	// colors by label number mod 13, white stays reserved for background
	localparam logic [COLOR_W-1:0] SHADE [NUM_COLORS] = '{
		24'hff00ff, 24'h009f4f, 24'hff0000, 24'h0000ff, 24'hff0000,
		24'hffff00, 24'h6f007f, 24'h00ff00, 24'h004f9f, 24'h7f9f00,
		24'haf006f, 24'h00ffff, 24'hff5f00
	};
	localparam logic [COLOR_W-1:0] BG_COLOR = 24'hffffff;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic               last;
	} pixel_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               ovf;
	} shade_t;

	logic clk = 1'b0;
	logic arst_n;

	slr_pix_if pix ();
	slr_rgb_if rgb ();

	segment_label_recolor_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.rgb    (rgb)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// pixels waiting to be offered, and colors predicted but not yet seen
	pixel_t pixels_pending [$];
	shade_t colors_due [$];

	// shadow of the label table: which labels are known in the current image
	logic [LABEL_W-1:0] known_label [MAX_LABELS];
	bit                 known_used [MAX_LABELS] = '{default: 1'b0};
	int unsigned        known_cnt = 0;
	// next label number mod 13, handed to the next unseen label
	int unsigned        next_number = 1 % NUM_COLORS;

	int  total_items = 0;
	int  taken_cnt = 0;
	int  err_cnt = 0;
	int  cyc_cnt = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	logic pix_took = 1'b0;
	logic calm = 1'b0;
	logic hold_rx = 1'b0;

	// color of one pixel, and the table update it causes
	function automatic shade_t recolor_pixel(input pixel_t px);
		shade_t res;
		int     slot;
		bit     hit;
		res.color = BG_COLOR;
		res.ovf = 1'b0;
		slot = 0;
		hit = 1'b0;
		if (px.label != '0) begin
			for (int i = 0; i < MAX_LABELS && !hit; i++) begin
				if (known_used[i] && known_label[i] == px.label) begin
					hit = 1'b1;
					slot = i;
				end
			end
			if (hit) begin
				// entry i holds label number i + 1
				res.color = SHADE[(slot + 1) % NUM_COLORS];
			end else begin
				res.color = SHADE[next_number];
				if (known_cnt < MAX_LABELS) begin
					known_label[known_cnt] = px.label;
					known_used[known_cnt] = 1'b1;
					known_cnt++;
				end else begin
					// table full: colored as new, not remembered
					res.ovf = 1'b1;
				end
				next_number = (next_number + 1) % NUM_COLORS;
			end
		end
		if (px.last) begin
			// image done, numbering restarts for the next one
			known_used = '{default: 1'b0};
			known_cnt = 0;
			next_number = 1 % NUM_COLORS;
		end
		return res;
	endfunction

	task automatic flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_SHOWN) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	task automatic add_pixel(input logic [LABEL_W-1:0] lab, input logic last);
		pixel_t px;
		px.label = lab;
		px.last = last;
		pixels_pending.push_back(px);
		total_items++;
	endtask

	// one image: a pool of labels, offered in pool order, then repeats;
	// background pixels and random labels from the pool are sprinkled in between
	task automatic add_image(input int npool, input int npix);
		logic [LABEL_W-1:0] pool [$];
		logic [LABEL_W-1:0] lab;
		int                 k;
		for (k = 0; k < npool; k++) begin
			if (npool > 64) begin
				// big pools need distinct labels to really fill the table
				lab = {15'($urandom_range(0, 32767)), 9'(k + 1)};
			end else begin
				lab = LABEL_W'($urandom());
				if (lab == '0) begin
					lab = 24'h000001;
				end
			end
			pool.push_back(lab);
		end
		for (k = 0; k < npix; k++) begin
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 1) == 0) begin
					add_pixel('0, 1'b0);
				end else begin
					add_pixel(pool[$urandom_range(0, npool - 1)], 1'b0);
				end
			end
			if (k < npool) begin
				lab = pool[k];
			end else begin
				lab = pool[$urandom_range(0, npool - 1)];
			end
			add_pixel(lab, k == npix - 1);
		end
	endtask

	// idling is allowed in three of every four stretches of cycles, and not at the end
	function automatic bit idle_allowed();
		return ((cyc_cnt / 97) % 4 != 0) && !calm;
	endfunction

	// driver: a new pixel goes out at the falling edge once the last one was taken
	always @(negedge clk) begin
		pixel_t px;
		if (arst_n) begin
			if (!pix.valid || pix_took) begin
				if (tx_gap > 0) begin
					tx_gap--;
					pix.valid <= 1'b0;
				end else if (idle_allowed() && $urandom_range(0, 4) == 0) begin
					// start an idle burst, this cycle included; tx_gap counts down the rest of it
					tx_gap = $urandom_range(0, 4);
					pix.valid <= 1'b0;
				end else if (pixels_pending.size() != 0) begin
					px = pixels_pending.pop_front();
					pix.valid <= 1'b1;
					pix.label <= px.label;
					pix.last_pixel <= px.last;
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: ready drops in short random bursts and during the long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_gap > 0) begin
				rx_gap--;
				rgb.ready <= 1'b0;
			end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(0, 4);
				rgb.ready <= 1'b0;
			end else begin
				rgb.ready <= !hold_rx;
			end
		end
	end

	// long receiver hold-off while pixels keep coming: the chain fills and
	// the block must push back on its input
	initial begin
		while (taken_cnt < 300) begin
			@(posedge clk);
		end
		hold_rx <= 1'b1;
		repeat (700) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// monitor: predict on each input transaction, check each output transaction
	always @(posedge clk) begin
		shade_t want;
		if (arst_n) begin
			pix_took <= pix.valid && pix.ready;
			if (pix.valid && pix.ready) begin
				want = recolor_pixel('{label: pix.label, last: pix.last_pixel});
				colors_due.push_back(want);
				taken_cnt++;
				calm <= (taken_cnt >= total_items - CALM_TAIL);
			end
			if (rgb.valid && rgb.ready) begin
				if (colors_due.size() == 0) begin
					flag_error($sformatf("color %h with no pixel pending", rgb.color));
				end else begin
					want = colors_due.pop_front();
					if (rgb.color !== want.color) begin
						flag_error($sformatf("color: expected %h got %h",
							want.color, rgb.color));
					end
					if (rgb.table_overflow !== want.ovf) begin
						flag_error($sformatf("table_overflow: expected %b got %b",
							want.ovf, rgb.table_overflow));
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc_cnt++;
		if (cyc_cnt >= CYCLE_LIMIT) begin
			$display("segment_label_recolor_core: mismatch");
			$finish;
		end
	end

	initial begin
		int bigs;
		int kind;
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.label = '0;
		pix.last_pixel = 1'b0;
		rgb.ready = 1'b0;
		bigs = 0;

		// directed: background, label extremes, known and new labels,
		// last pixel on a known, a new and a background pixel
		add_pixel(24'h000000, 1'b0);
		add_pixel(24'hffffff, 1'b0);
		add_pixel(24'h000001, 1'b0);
		add_pixel(24'hffffff, 1'b0);
		add_pixel(24'h800000, 1'b0);
		add_pixel(24'h7fffff, 1'b0);
		add_pixel(24'h000000, 1'b0);
		add_pixel(24'h000001, 1'b0);
		add_pixel(24'h555555, 1'b0);
		add_pixel(24'haaaaaa, 1'b0);
		add_pixel(24'h800000, 1'b1);
		// same label again after the clear counts as new
		add_pixel(24'hffffff, 1'b0);
		add_pixel(24'h000000, 1'b1);
		add_pixel(24'h000001, 1'b1);
		add_pixel(24'h000001, 1'b0);
		add_pixel(24'h123456, 1'b0);
		add_pixel(24'h123456, 1'b0);
		add_pixel(24'h000000, 1'b0);
		add_pixel(24'hfedcba, 1'b1);

		// an image with more labels than the table holds, so overflow shows early
		add_image(MAX_LABELS + $urandom_range(1, 24), MAX_LABELS + $urandom_range(30, 60));
		bigs = 1;
		while (total_items < ITEM_TARGET) begin
			kind = $urandom_range(0, 19);
			if (kind == 0 && bigs < 2) begin
				add_image(MAX_LABELS + $urandom_range(1, 24),
					MAX_LABELS + $urandom_range(30, 60));
				bigs++;
			end else if (kind <= 2) begin
				// noise: a lone pixel with any label and any last flag
				add_pixel(LABEL_W'($urandom()), 1'($urandom_range(0, 1)));
			end else begin
				add_image($urandom_range(1, 24), $urandom_range(1, 48));
			end
		end

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// all pixels offered and taken, then all colors back, then a quiet drain
		while (pixels_pending.size() != 0 || pix.valid) begin
			@(posedge clk);
		end
		while (colors_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0) begin
			$display("segment_label_recolor_core: match");
		end else begin
			$display("segment_label_recolor_core: mismatch");
		end
		$finish;
	end

endmodule
